// ===== src/mse_pkg.sv =====
// Package for the MIPS subset execute unit: opcode and funct codes, and the
// control word that the decoder hands to the pipeline.
// No dependencies.
package mse_pkg;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ANDI  = 6'h0c;
    localparam logic [5:0] OP_ORI   = 6'h0d;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2b;

    localparam logic [5:0] FN_SLL = 6'h00;
    localparam logic [5:0] FN_SRL = 6'h02;
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_XOR = 6'h27;
    localparam logic [5:0] FN_SLT = 6'h2a;

    typedef struct packed {
        logic        wr;        // Nonzero destination register is written.
        logic [4:0]  dest;
        logic [31:0] value;     // ALU result, store data, or zero.
        logic        is_load;
        logic        is_store;
        logic        unknown;
        logic [31:0] pc_next;
    } exec_ctl_t;

endpackage

// ===== src/mse_exec.sv =====
// Instruction decode, ALU, branch and jump target logic of the execute unit.
// Depends on mse_pkg.
module mse_exec
    import mse_pkg::*;
(
    input  logic [31:0] ins,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] pc,
    output exec_ctl_t   ctl,
    output logic [31:0] mem_addr
);

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] imm_sx;
    logic [31:0] imm_zx;

    assign op     = ins[31:26];
    assign rt     = ins[20:16];
    assign rd     = ins[15:11];
    assign sh     = ins[10:6];
    assign fn     = ins[5:0];
    assign imm_sx = {{16{ins[15]}}, ins[15:0]};
    assign imm_zx = {16'd0, ins[15:0]};

    assign mem_addr = a + imm_sx;

    always_comb
    begin
        logic        wr;
        logic [4:0]  dest;
        logic [31:0] result;
        wr     = 1'b0;
        dest   = 5'd0;
        result = 32'd0;
        ctl    = '0;
        ctl.pc_next = pc;
        case (op)
            OP_RTYPE:
            begin
                wr   = 1'b1;
                dest = rd;
                case (fn)
                    FN_AND: result = a & b;
                    FN_OR:  result = a | b;
                    FN_XOR: result = a ^ b;
                    FN_ADD: result = a + b;
                    FN_SUB: result = a - b;
                    FN_SLL: result = b << sh;
                    FN_SRL: result = b >> sh;
                    FN_SLT: result = {31'd0, $signed(a) < $signed(b)};
                    default:
                    begin
                        wr          = 1'b0;
                        ctl.unknown = 1'b1;
                    end
                endcase
            end
            OP_BEQ:
            begin
                if (a == b)
                begin
                    ctl.pc_next = pc + imm_sx;
                end
            end
            OP_LW:
            begin
                wr          = 1'b1;
                dest        = rt;
                ctl.is_load = 1'b1;
            end
            OP_SW:   ctl.is_store = 1'b1;
            OP_ANDI:
            begin
                wr     = 1'b1;
                dest   = rt;
                result = a & imm_zx;
            end
            OP_ORI:
            begin
                wr     = 1'b1;
                dest   = rt;
                result = a | imm_zx;
            end
            OP_ADDI:
            begin
                wr     = 1'b1;
                dest   = rt;
                result = a + imm_sx;
            end
            OP_J:    ctl.pc_next = {pc[31:26], ins[25:0]};
            default: ctl.unknown = 1'b1;
        endcase

        // Register zero is never written, so such results report no write.
        if (!wr || dest == 5'd0)
        begin
            ctl.wr   = 1'b0;
            ctl.dest = 5'd0;
        end
        else
        begin
            ctl.wr   = 1'b1;
            ctl.dest = dest;
        end

        if (ctl.wr)
        begin
            ctl.value = result;
        end
        else if (ctl.is_store)
        begin
            ctl.value = b;
        end
        else
        begin
            ctl.value = 32'd0;
        end
    end

endmodule

// ===== src/mips_subset_execute_unit.sv =====
// Top level of the MIPS subset execute unit: register file and data memory,
// five-stage pipeline with forwarding and a load interlock, APB register port.
// Depends on mse_pkg and mse_exec.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------------
//  instr     | in        | instr_valid / instr_ready  | instruction
//  result    | out       | result_valid / result_ready| pc_after, reg_written, dest_reg,
//            |           |                            | write_value, mem_stored, unknown_op
//  apb       | in/out    | psel, penable, pready      | paddr, pwrite, pwdata, prdata
//
// A word is taken every cycle unless the pipeline holds, a load wait or the memory clear
// stops it; its result goes through the two address stages and write-back to the output.
// An instruction that reads the destination of a load still in the two address stages
// waits until the load data comes out of the data memory. After reset the data memory
// is cleared, one word a cycle from index 0 to DATA_WORDS-1; no word is taken during that pass.
// When result_ready is low with a result waiting, the whole pipeline holds.
module mips_subset_execute_unit
    import mse_pkg::*;
#(
    parameter int unsigned DATA_WORDS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        instr_valid,
    output logic        instr_ready,
    input  logic [31:0] instruction,

    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] pc_after,
    output logic        reg_written,
    output logic [4:0]  dest_reg,
    output logic [31:0] write_value,
    output logic        mem_stored,
    output logic        unknown_op,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int          IDX_W      = $clog2(DATA_WORDS);
    localparam int          SHIFT      = 30 + IDX_W;
    localparam logic [63:0] RECIP_WIDE = ((64'd1 << SHIFT) + 64'(DATA_WORDS) - 64'd1)
                                         / 64'(DATA_WORDS);
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
    localparam logic        REG_START  = 1'b0;

    // Storage.
    logic [31:0] rf_mem [32];
    logic [31:0] dm_mem [DATA_WORDS];
    logic [31:0] rf_vld_reg;

    // Control state.
    logic             clr_active_reg;
    logic [IDX_W-1:0] clr_idx_reg;
    logic [31:0]      pc_reg;
    logic [31:0]      start_reg;

    logic e_valid_reg, e_first_reg;
    logic x_valid_reg, y_valid_reg, w_valid_reg;
    logic result_valid_reg;
    logic wbl_valid_reg;

    // Payload registers.
    logic [31:0] e_ins_reg;
    logic [31:0] e_a_reg, e_b_reg;
    logic [31:0] rf_rs_reg, rf_rt_reg;
    logic        rs_hit_reg, rt_hit_reg;
    exec_ctl_t   x_ctl_reg, y_ctl_reg, w_ctl_reg;
    logic [29:0] x_word_reg, y_word_reg, y_quot_reg;
    logic [31:0] dm_rdata_reg;
    logic [4:0]  wbl_dest_reg;
    logic [31:0] wbl_value_reg;
    logic [31:0] pc_after_reg, write_value_reg;
    logic [4:0]  dest_reg_reg;
    logic        reg_written_reg, mem_stored_reg, unknown_op_reg;

    // Combinational signals.
    logic             adv;
    logic             hazard;
    logic             e_go;
    logic             accept;
    logic [4:0]       e_rs, e_rt;
    logic [31:0]      e_a, e_b;
    logic [31:0]      w_value;
    exec_ctl_t        e_ctl;
    logic [31:0]      e_addr;
    logic [61:0]      x_prod;
    logic [61:0]      x_quot_wide;
    logic [29:0]      y_qd;
    logic [29:0]      y_rem;
    logic [IDX_W-1:0] y_idx;
    logic             dm_we, dm_re;
    logic [IDX_W-1:0] dm_waddr;
    logic [31:0]      dm_wdata;
    logic             rf_we;
    logic             cfg_wr;
    logic [31:0]      pc_next;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_START);
    assign prdata = (paddr[2] == REG_START) ? start_reg : 32'd0;

    // The pipeline moves as one whenever the output register can take a word.
    assign adv    = !result_valid_reg || result_ready;
    assign e_rs   = e_ins_reg[25:21];
    assign e_rt   = e_ins_reg[20:16];
    assign hazard = e_valid_reg &&
                    ((x_valid_reg && x_ctl_reg.is_load && x_ctl_reg.wr &&
                      (x_ctl_reg.dest == e_rs || x_ctl_reg.dest == e_rt)) ||
                     (y_valid_reg && y_ctl_reg.is_load && y_ctl_reg.wr &&
                      (y_ctl_reg.dest == e_rs || y_ctl_reg.dest == e_rt)));
    assign e_go        = e_valid_reg && adv && !hazard;
    assign instr_ready = !clr_active_reg && (!e_valid_reg || e_go);
    assign accept      = instr_valid && instr_ready;

    assign w_value = w_ctl_reg.is_load ? dm_rdata_reg : w_ctl_reg.value;
    assign rf_we   = adv && w_valid_reg && w_ctl_reg.wr;

    // Operand forwarding: the youngest pending write wins. In the first cycle
    // the base is the register file read; after that it is the operand saved
    // in the previous cycle.
    always_comb
    begin
        e_a = e_first_reg ? (rs_hit_reg ? rf_rs_reg : 32'd0) : e_a_reg;
        e_b = e_first_reg ? (rt_hit_reg ? rf_rt_reg : 32'd0) : e_b_reg;
        if (wbl_valid_reg && wbl_dest_reg == e_rs)
        begin
            e_a = wbl_value_reg;
        end
        if (wbl_valid_reg && wbl_dest_reg == e_rt)
        begin
            e_b = wbl_value_reg;
        end
        if (w_valid_reg && w_ctl_reg.wr && w_ctl_reg.dest == e_rs)
        begin
            e_a = w_value;
        end
        if (w_valid_reg && w_ctl_reg.wr && w_ctl_reg.dest == e_rt)
        begin
            e_b = w_value;
        end
        if (y_valid_reg && y_ctl_reg.wr && !y_ctl_reg.is_load && y_ctl_reg.dest == e_rs)
        begin
            e_a = y_ctl_reg.value;
        end
        if (y_valid_reg && y_ctl_reg.wr && !y_ctl_reg.is_load && y_ctl_reg.dest == e_rt)
        begin
            e_b = y_ctl_reg.value;
        end
        if (x_valid_reg && x_ctl_reg.wr && !x_ctl_reg.is_load && x_ctl_reg.dest == e_rs)
        begin
            e_a = x_ctl_reg.value;
        end
        if (x_valid_reg && x_ctl_reg.wr && !x_ctl_reg.is_load && x_ctl_reg.dest == e_rt)
        begin
            e_b = x_ctl_reg.value;
        end
    end

    mse_exec u_exec
    (
        .ins      (e_ins_reg),
        .a        (e_a),
        .b        (e_b),
        .pc       (pc_reg),
        .ctl      (e_ctl),
        .mem_addr (e_addr)
    );

    // Word index modulo DATA_WORDS: exact reciprocal multiply, then subtract.
    assign x_prod      = 62'(x_word_reg) * 62'(RECIP);
    assign x_quot_wide = x_prod >> SHIFT;
    assign y_qd        = 30'(y_quot_reg * 30'(DATA_WORDS));
    assign y_rem       = y_word_reg - y_qd;
    assign y_idx       = y_rem[IDX_W-1:0];

    assign dm_re    = adv && y_valid_reg && y_ctl_reg.is_load;
    assign dm_we    = clr_active_reg || (adv && y_valid_reg && y_ctl_reg.is_store);
    assign dm_waddr = clr_active_reg ? clr_idx_reg : y_idx;
    assign dm_wdata = clr_active_reg ? 32'd0 : y_ctl_reg.value;

    always_comb
    begin
        pc_next = pc_reg;
        if (cfg_wr)
        begin
            pc_next = {2'b00, pwdata[31:2]};
        end
        else if (e_go)
        begin
            pc_next = e_ctl.pc_next;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg   <= 1'b1;
            clr_idx_reg      <= '0;
            pc_reg           <= 32'd0;
            start_reg        <= 32'd0;
            e_valid_reg      <= 1'b0;
            e_first_reg      <= 1'b0;
            x_valid_reg      <= 1'b0;
            y_valid_reg      <= 1'b0;
            w_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            wbl_valid_reg    <= 1'b0;
            rf_vld_reg       <= 32'd0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_idx_reg == IDX_W'(DATA_WORDS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cfg_wr)
            begin
                start_reg <= pwdata;
            end
            pc_reg <= pc_next;

            if (accept)
            begin
                e_valid_reg <= 1'b1;
                e_first_reg <= 1'b1;
            end
            else
            begin
                if (e_go)
                begin
                    e_valid_reg <= 1'b0;
                end
                e_first_reg <= 1'b0;
            end

            if (adv)
            begin
                x_valid_reg      <= e_go;
                y_valid_reg      <= x_valid_reg;
                w_valid_reg      <= y_valid_reg;
                result_valid_reg <= w_valid_reg;
            end
            if (rf_we)
            begin
                rf_vld_reg[w_ctl_reg.dest] <= 1'b1;
                wbl_valid_reg              <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        e_a_reg <= e_a;
        e_b_reg <= e_b;
        if (accept)
        begin
            e_ins_reg  <= instruction;
            rs_hit_reg <= rf_vld_reg[instruction[25:21]];
            rt_hit_reg <= rf_vld_reg[instruction[20:16]];
        end
        if (adv)
        begin
            x_ctl_reg  <= e_ctl;
            x_word_reg <= e_addr[31:2];
            y_ctl_reg  <= x_ctl_reg;
            y_word_reg <= x_word_reg;
            y_quot_reg <= x_quot_wide[29:0];
            w_ctl_reg  <= y_ctl_reg;
            if (w_valid_reg)
            begin
                pc_after_reg    <= w_ctl_reg.pc_next;
                reg_written_reg <= w_ctl_reg.wr;
                dest_reg_reg    <= w_ctl_reg.dest;
                write_value_reg <= w_ctl_reg.wr ? w_value : w_ctl_reg.value;
                mem_stored_reg  <= w_ctl_reg.is_store;
                unknown_op_reg  <= w_ctl_reg.unknown;
            end
        end
        if (rf_we)
        begin
            wbl_dest_reg  <= w_ctl_reg.dest;
            wbl_value_reg <= w_value;
        end
    end

    // Register file: two read ports at acceptance, one write port at write-back.
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[w_ctl_reg.dest] <= w_value;
        end
        if (accept)
        begin
            rf_rs_reg <= rf_mem[instruction[25:21]];
            rf_rt_reg <= rf_mem[instruction[20:16]];
        end
    end

    // Data memory: one write and one read port; apart from the clear after reset, all accesses
    // happen in order at the end of the second address stage.
    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dm_mem[dm_waddr] <= dm_wdata;
        end
        if (dm_re)
        begin
            dm_rdata_reg <= dm_mem[y_idx];
        end
    end

    assign result_valid = result_valid_reg;
    assign pc_after     = pc_after_reg;
    assign reg_written  = reg_written_reg;
    assign dest_reg     = dest_reg_reg;
    assign write_value  = write_value_reg;
    assign mem_stored   = mem_stored_reg;
    assign unknown_op   = unknown_op_reg;

    // No instruction may be in flight while the data memory is being cleared.
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !(e_valid_reg || x_valid_reg || y_valid_reg || w_valid_reg))
        else $error("instruction in flight during data memory clear");

    // Register zero is never a write-back target.
    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> w_ctl_reg.dest != 5'd0)
        else $error("write-back to register zero");

    // A write-back marks its register valid and is kept for forwarding.
    a_wb_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |=> wbl_valid_reg && wbl_dest_reg == $past(w_ctl_reg.dest) &&
                  rf_vld_reg[$past(w_ctl_reg.dest)])
        else $error("write-back not tracked");

    // A result never both writes a register and stores, and unknown codes do neither.
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(reg_written && mem_stored) &&
                         !(unknown_op && (reg_written || mem_stored)))
        else $error("inconsistent result flags");

endmodule
